// ----- rtl/cxsm_pkg.sv -----
package cxsm_pkg;

    localparam int NUM_STAGES = 11;
    localparam int MIX_STAGE  = 5;
    localparam int MIX_STAGES = NUM_STAGES - MIX_STAGE;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROLL_FACTORS      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_FACTORS     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_LIMIT        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECTIVE_LOW    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECTIVE_HIGH   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECTIVE_TARGET = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_TRIMS       = 4'd7;

    localparam logic [12:0] LIMIT_RESET       = 13'd4500;
    localparam logic [10:0] COLL_LOW_RESET    = 11'd1250;
    localparam logic [10:0] COLL_HIGH_RESET   = 11'd1750;
    localparam logic [11:0] COLL_TARGET_RESET = 12'd500;
    localparam logic [10:0] TRIM_RESET        = 11'd1500;

    localparam int YAW_MIN_THROTTLE = 200;
    localparam int YAW_LIMIT        = 100;
    localparam int COLL_FULL        = 1000;
    localparam int TRIM_CENTER      = 1500;

    // floor(x / d) == (x * ceil(2^sh / d)) >> sh over the operand range used
    localparam int          RECIP_4500_SH = 41;
    localparam int          RECIP_4500_W  = 29;
    localparam logic [28:0] RECIP_4500    = 29'd488671835;
    localparam int          RECIP_9_SH    = 24;
    localparam int          RECIP_9_W     = 21;
    localparam logic [20:0] RECIP_9       = 21'd1864136;
    localparam int          RECIP_1000_SH = 34;
    localparam int          RECIP_1000_W  = 25;
    localparam logic [24:0] RECIP_1000    = 25'd17179870;
    localparam int          RECIP_10_SH   = 28;
    localparam int          RECIP_10_W    = 25;
    localparam logic [24:0] RECIP_10      = 25'd26843546;

    typedef struct packed {
        logic [47:0] roll_factors;
        logic [47:0] pitch_factors;
        logic [12:0] roll_limit;
        logic [12:0] pitch_limit;
        logic [10:0] collective_low;
        logic [10:0] collective_high;
        logic [11:0] collective_target;
        logic [32:0] servo_trims;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cw_drive;
        logic [15:0] ccw_drive;
        logic        limit_roll_pitch;
        logic        limit_yaw;
        logic        limit_coll_low;
        logic        limit_coll_high;
    } side_t;

endpackage

// ----- rtl/cxsm_cmd_scale.sv -----
module cxsm_cmd_scale #(
    parameter int DEFAULT_COLL_MIN = 1250,
    parameter int DEFAULT_COLL_MAX = 1750
) (
    input  logic                                aclk,
    input  logic [cxsm_pkg::NUM_STAGES-1:0]     en,
    input  cxsm_pkg::cfg_t                      cfg,
    input  logic signed [15:0]                  roll_cmd,
    input  logic signed [15:0]                  pitch_cmd,
    input  logic signed [15:0]                  throttle_cmd,
    input  logic signed [15:0]                  yaw_cmd,
    input  logic [1:0]                          rotor_mode,
    output logic signed [13:0]                  roll,
    output logic signed [13:0]                  pitch,
    output logic signed [12:0]                  coll_scaled,
    output cxsm_pkg::side_t                     side
);
    import cxsm_pkg::*;

    localparam int RPM_W = 28 + RECIP_4500_W;
    localparam int YPM_W = 17 + RECIP_9_W;
    localparam int CPM_W = 22 + RECIP_1000_W;

    function automatic logic [15:0] sat16(input logic signed [16:0] v);
        logic [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'h7fff;
        end else if (v < -17'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // stage 0: products, collective clamp and range
    logic signed [29:0] roll_prod_c, pitch_prod_c;
    logic signed [11:0] coll_tgt;
    logic [9:0]         coll_c;
    logic               clo_c, chi_c;
    logic [10:0]        lo_c, hi_c, span_c;
    logic signed [11:0] lo_ofs_c;
    logic [20:0]        cprod_c;
    logic signed [21:0] cofs_c;

    assign roll_prod_c  = roll_cmd * $signed({1'b0, cfg.roll_limit});
    assign pitch_prod_c = pitch_cmd * $signed({1'b0, cfg.pitch_limit});
    assign coll_tgt     = $signed(cfg.collective_target);

    always_comb begin
        coll_c = '0;
        clo_c  = 1'b0;
        chi_c  = 1'b0;
        if (coll_tgt <= 12'sd0) begin
            clo_c = 1'b1;
        end else if (coll_tgt >= $signed(12'(COLL_FULL))) begin
            coll_c = 10'(COLL_FULL);
            chi_c  = 1'b1;
        end else begin
            coll_c = coll_tgt[9:0];
        end
    end

    always_comb begin
        if (cfg.collective_low >= cfg.collective_high) begin
            lo_c = 11'(DEFAULT_COLL_MIN);
            hi_c = 11'(DEFAULT_COLL_MAX);
        end else begin
            lo_c = cfg.collective_low;
            hi_c = cfg.collective_high;
        end
    end

    assign span_c   = hi_c - lo_c;
    assign cprod_c  = 21'(coll_c) * 21'(span_c);
    assign lo_ofs_c = $signed({1'b0, lo_c}) - $signed(12'(COLL_FULL));
    assign cofs_c   = 22'(lo_ofs_c) * $signed(22'(COLL_FULL));

    logic signed [29:0] roll_prod_reg, pitch_prod_reg;
    logic signed [16:0] yaw_x2_reg;
    logic [20:0]        cprod_reg;
    logic signed [21:0] cofs_reg;
    logic signed [15:0] thr0_reg;
    logic               yen0_reg, act0_reg, clo0_reg, chi0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            roll_prod_reg  <= roll_prod_c;
            pitch_prod_reg <= pitch_prod_c;
            yaw_x2_reg     <= {yaw_cmd, 1'b0};
            cprod_reg      <= cprod_c;
            cofs_reg       <= cofs_c;
            thr0_reg       <= throttle_cmd;
            yen0_reg       <= throttle_cmd >= $signed(16'(YAW_MIN_THROTTLE));
            act0_reg       <= rotor_mode[1];
            clo0_reg       <= clo_c;
            chi0_reg       <= chi_c;
        end
    end

    // stage 1: magnitudes, collective numerator
    logic [29:0] roll_abs_c, pitch_abs_c;
    logic [16:0] yaw_abs_c;

    assign roll_abs_c  = roll_prod_reg[29] ? 30'(-roll_prod_reg) : 30'(roll_prod_reg);
    assign pitch_abs_c = pitch_prod_reg[29] ? 30'(-pitch_prod_reg) : 30'(pitch_prod_reg);
    assign yaw_abs_c   = yaw_x2_reg[16] ? 17'(-yaw_x2_reg) : 17'(yaw_x2_reg);

    logic [27:0]        roll_mag1_reg, pitch_mag1_reg;
    logic [16:0]        yaw_mag1_reg;
    logic               roll_neg1_reg, pitch_neg1_reg, yaw_neg1_reg;
    logic signed [22:0] cnum1_reg;
    logic signed [15:0] thr1_reg;
    logic               yen1_reg, act1_reg, clo1_reg, chi1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            roll_mag1_reg  <= roll_abs_c[27:0];
            pitch_mag1_reg <= pitch_abs_c[27:0];
            yaw_mag1_reg   <= yaw_abs_c;
            roll_neg1_reg  <= roll_prod_reg[29];
            pitch_neg1_reg <= pitch_prod_reg[29];
            yaw_neg1_reg   <= yaw_x2_reg[16];
            cnum1_reg      <= $signed({2'b00, cprod_reg}) + 23'(cofs_reg);
            thr1_reg       <= thr0_reg;
            yen1_reg       <= yen0_reg;
            act1_reg       <= act0_reg;
            clo1_reg       <= clo0_reg;
            chi1_reg       <= chi0_reg;
        end
    end

    // stage 2: reciprocal multiplies
    logic [22:0] cnum_abs_c;
    assign cnum_abs_c = cnum1_reg[22] ? 23'(-cnum1_reg) : 23'(cnum1_reg);

    logic [RPM_W-1:0]   roll_pm2_reg, pitch_pm2_reg;
    logic [YPM_W-1:0]   yaw_pm2_reg;
    logic [21:0]        cmag2_reg;
    logic               roll_neg2_reg, pitch_neg2_reg, yaw_neg2_reg, cneg2_reg;
    logic signed [15:0] thr2_reg;
    logic               yen2_reg, act2_reg, clo2_reg, chi2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            roll_pm2_reg   <= RPM_W'(roll_mag1_reg) * RPM_W'(RECIP_4500);
            pitch_pm2_reg  <= RPM_W'(pitch_mag1_reg) * RPM_W'(RECIP_4500);
            yaw_pm2_reg    <= YPM_W'(yaw_mag1_reg) * YPM_W'(RECIP_9);
            cmag2_reg      <= cnum_abs_c[21:0];
            roll_neg2_reg  <= roll_neg1_reg;
            pitch_neg2_reg <= pitch_neg1_reg;
            yaw_neg2_reg   <= yaw_neg1_reg;
            cneg2_reg      <= cnum1_reg[22];
            thr2_reg       <= thr1_reg;
            yen2_reg       <= yen1_reg;
            act2_reg       <= act1_reg;
            clo2_reg       <= clo1_reg;
            chi2_reg       <= chi1_reg;
        end
    end

    // stage 3: quotients, clamps, collective reciprocal
    logic [15:0] roll_q_c, pitch_q_c;
    logic [13:0] yaw_q_c;
    logic [12:0] roll_m_c, pitch_m_c;
    logic [6:0]  yaw_m_c;
    logic        roll_clip_c, pitch_clip_c, yaw_clip_c;

    assign roll_q_c  = roll_pm2_reg[RECIP_4500_SH +: 16];
    assign pitch_q_c = pitch_pm2_reg[RECIP_4500_SH +: 16];
    assign yaw_q_c   = yaw_pm2_reg[RECIP_9_SH +: 14];

    always_comb begin
        roll_clip_c = roll_q_c > {3'b000, cfg.roll_limit};
        roll_m_c    = roll_clip_c ? cfg.roll_limit : roll_q_c[12:0];
        pitch_clip_c = pitch_q_c > {3'b000, cfg.pitch_limit};
        pitch_m_c    = pitch_clip_c ? cfg.pitch_limit : pitch_q_c[12:0];
    end

    always_comb begin
        if (!yen2_reg) begin
            yaw_m_c    = '0;
            yaw_clip_c = 1'b1;
        end else if (yaw_q_c > 14'(YAW_LIMIT)) begin
            yaw_m_c    = 7'(YAW_LIMIT);
            yaw_clip_c = 1'b1;
        end else begin
            yaw_m_c    = yaw_q_c[6:0];
            yaw_clip_c = 1'b0;
        end
    end

    logic signed [13:0] roll3_reg, pitch3_reg;
    logic signed [7:0]  yaw3_reg;
    logic [CPM_W-1:0]   cpm3_reg;
    logic               cneg3_reg;
    logic signed [15:0] thr3_reg;
    logic               act3_reg, clo3_reg, chi3_reg, frp3_reg, fyaw3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            roll3_reg  <= roll_neg2_reg ? -$signed({1'b0, roll_m_c}) : $signed({1'b0, roll_m_c});
            pitch3_reg <= pitch_neg2_reg ? -$signed({1'b0, pitch_m_c})
                                         : $signed({1'b0, pitch_m_c});
            yaw3_reg   <= yaw_neg2_reg ? -$signed({1'b0, yaw_m_c}) : $signed({1'b0, yaw_m_c});
            cpm3_reg   <= CPM_W'(cmag2_reg) * CPM_W'(RECIP_1000);
            cneg3_reg  <= cneg2_reg;
            thr3_reg   <= thr2_reg;
            act3_reg   <= act2_reg;
            clo3_reg   <= clo2_reg;
            chi3_reg   <= chi2_reg;
            frp3_reg   <= roll_clip_c | pitch_clip_c;
            fyaw3_reg  <= yaw_clip_c;
        end
    end

    // stage 4: collective term, rotor drives
    logic [12:0]        cs_mag_c;
    logic signed [16:0] cw_c, ccw_c;
    side_t              side_c;

    assign cs_mag_c = cpm3_reg[RECIP_1000_SH +: 13];
    assign cw_c     = 17'(thr3_reg) - 17'(yaw3_reg);
    assign ccw_c    = 17'(thr3_reg) + 17'(yaw3_reg);

    always_comb begin
        side_c.cw_drive         = act3_reg ? sat16(cw_c) : 16'h0000;
        side_c.ccw_drive        = act3_reg ? sat16(ccw_c) : 16'h0000;
        side_c.limit_roll_pitch = frp3_reg;
        side_c.limit_yaw        = fyaw3_reg;
        side_c.limit_coll_low   = clo3_reg;
        side_c.limit_coll_high  = chi3_reg;
    end

    logic signed [13:0] roll4_reg, pitch4_reg;
    logic signed [12:0] cs4_reg;
    side_t              side_reg [MIX_STAGE-1:NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (en[MIX_STAGE-1]) begin
            roll4_reg  <= roll3_reg;
            pitch4_reg <= pitch3_reg;
            cs4_reg    <= cneg3_reg ? -$signed(cs_mag_c) : $signed(cs_mag_c);
        end
    end

    // drives and flags ride alongside the servo mix stages
    always_ff @(posedge aclk) begin
        if (en[MIX_STAGE-1]) begin
            side_reg[MIX_STAGE-1] <= side_c;
        end
        for (int k = MIX_STAGE; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign roll        = roll4_reg;
    assign pitch       = pitch4_reg;
    assign coll_scaled = cs4_reg;
    assign side        = side_reg[NUM_STAGES-1];

endmodule

// ----- rtl/cxsm_servo_mix.sv -----
module cxsm_servo_mix #(
    parameter int FACTOR_FRAC_BITS = 14
) (
    input  logic                              aclk,
    input  logic [cxsm_pkg::MIX_STAGES-1:0]   en,
    input  logic signed [13:0]                roll,
    input  logic signed [13:0]                pitch,
    input  logic signed [12:0]                coll_scaled,
    input  logic signed [15:0]                factor_roll,
    input  logic signed [15:0]                factor_pitch,
    input  logic [10:0]                       trim,
    output logic signed [15:0]                servo
);
    import cxsm_pkg::*;

    localparam int NUM_W = (FACTOR_FRAC_BITS > 14) ? FACTOR_FRAC_BITS + 17 : 31;
    localparam int X_W   = NUM_W - FACTOR_FRAC_BITS;
    localparam int XM_W  = X_W + RECIP_10_W;
    localparam int Q_W   = XM_W - RECIP_10_SH;

    // stage 0: factor products, trim offset
    logic signed [13:0] b_c;
    assign b_c = 14'(coll_scaled) + $signed({3'b000, trim}) - $signed(14'(TRIM_CENTER));

    logic signed [29:0] pr_reg, pp_reg;
    logic signed [12:0] b_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pr_reg <= factor_roll * roll;
            pp_reg <= factor_pitch * pitch;
            b_reg  <= b_c[12:0];
        end
    end

    // stage 1
    logic signed [30:0] a_reg;
    logic signed [15:0] b10_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            a_reg   <= 31'(pr_reg) + 31'(pp_reg);
            b10_reg <= 16'(b_reg) * 16'sd10;
        end
    end

    // stage 2: full numerator over 10 * 2^F
    logic signed [NUM_W-1:0] num_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            num_reg <= NUM_W'(a_reg) + (NUM_W'(b10_reg) <<< FACTOR_FRAC_BITS);
        end
    end

    // stage 3: magnitude, drop fraction bits
    logic [NUM_W-1:0] mag_c;
    assign mag_c = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    logic [X_W-1:0] x_reg;
    logic           neg3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            x_reg    <= mag_c[NUM_W-1:FACTOR_FRAC_BITS];
            neg3_reg <= num_reg[NUM_W-1];
        end
    end

    // stage 4: divide by ten
    logic [XM_W-1:0] xm_reg;
    logic            neg4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            xm_reg   <= XM_W'(x_reg) * XM_W'(RECIP_10);
            neg4_reg <= neg3_reg;
        end
    end

    // stage 5: sign and saturate into the output register
    logic [Q_W-1:0]   q_c;
    logic [NUM_W-1:0] qe_c;
    logic [15:0]      sat_c;

    assign q_c  = xm_reg[XM_W-1:RECIP_10_SH];
    assign qe_c = {{(NUM_W-Q_W){1'b0}}, q_c};

    always_comb begin
        if (!neg4_reg) begin
            sat_c = (qe_c > NUM_W'(32767)) ? 16'h7fff : qe_c[15:0];
        end else begin
            sat_c = (qe_c > NUM_W'(32768)) ? 16'h8000 : 16'(-qe_c[15:0]);
        end
    end

    logic signed [15:0] servo_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            servo_reg <= $signed(sat_c);
        end
    end

    assign servo = servo_reg;

endmodule

// ----- rtl/coax_swashplate_mixer.sv -----
// Pipeline: an accepted input transaction passes through 11 register stages to m_valid.
// Throughput: one transaction per cycle while m_ready does not hold the output;
// the ready chain runs stage by stage, so empty stages keep accepting input
// while a result waits on m_ready.
// Reset (aresetn low, synchronous): all stage valids clear, config registers
// load their reset values; payload registers are not reset.
module coax_swashplate_mixer #(
    parameter int FACTOR_FRAC_BITS = 14,
    parameter int DEFAULT_COLL_MIN = 1250,
    parameter int DEFAULT_COLL_MAX = 1750
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_roll_cmd,
    input  logic signed [15:0]                  s_pitch_cmd,
    input  logic signed [15:0]                  s_throttle_cmd,
    input  logic signed [15:0]                  s_yaw_cmd,
    input  logic [1:0]                          s_rotor_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_servo_one,
    output logic signed [15:0]                  m_servo_two,
    output logic signed [15:0]                  m_servo_three,
    output logic signed [15:0]                  m_cw_drive,
    output logic signed [15:0]                  m_ccw_drive,
    output logic                                m_limit_roll_pitch,
    output logic                                m_limit_yaw,
    output logic                                m_limit_coll_low,
    output logic                                m_limit_coll_high,
    input  logic                                cfg_wr_en,
    input  logic [cxsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cxsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import cxsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.roll_factors      <= '0;
            cfg_reg.pitch_factors     <= '0;
            cfg_reg.roll_limit        <= LIMIT_RESET;
            cfg_reg.pitch_limit       <= LIMIT_RESET;
            cfg_reg.collective_low    <= COLL_LOW_RESET;
            cfg_reg.collective_high   <= COLL_HIGH_RESET;
            cfg_reg.collective_target <= COLL_TARGET_RESET;
            cfg_reg.servo_trims       <= {TRIM_RESET, TRIM_RESET, TRIM_RESET};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROLL_FACTORS:      cfg_reg.roll_factors      <= cfg_wdata[47:0];
                REG_PITCH_FACTORS:     cfg_reg.pitch_factors     <= cfg_wdata[47:0];
                REG_ROLL_LIMIT:        cfg_reg.roll_limit        <= cfg_wdata[12:0];
                REG_PITCH_LIMIT:       cfg_reg.pitch_limit       <= cfg_wdata[12:0];
                REG_COLLECTIVE_LOW:    cfg_reg.collective_low    <= cfg_wdata[10:0];
                REG_COLLECTIVE_HIGH:   cfg_reg.collective_high   <= cfg_wdata[10:0];
                REG_COLLECTIVE_TARGET: cfg_reg.collective_target <= cfg_wdata[11:0];
                REG_SERVO_TRIMS:       cfg_reg.servo_trims       <= cfg_wdata[32:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;

    assign en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    logic signed [13:0] roll, pitch;
    logic signed [12:0] coll_scaled;
    side_t              side;

    cxsm_cmd_scale #(
        .DEFAULT_COLL_MIN (DEFAULT_COLL_MIN),
        .DEFAULT_COLL_MAX (DEFAULT_COLL_MAX)
    ) u_cmd_scale (
        .aclk         (aclk),
        .en           (en),
        .cfg          (cfg_reg),
        .roll_cmd     (s_roll_cmd),
        .pitch_cmd    (s_pitch_cmd),
        .throttle_cmd (s_throttle_cmd),
        .yaw_cmd      (s_yaw_cmd),
        .rotor_mode   (s_rotor_mode),
        .roll         (roll),
        .pitch        (pitch),
        .coll_scaled  (coll_scaled),
        .side         (side)
    );

    logic signed [15:0] servo [3];

    for (genvar k = 0; k < 3; k++) begin : g_servo
        cxsm_servo_mix #(
            .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
        ) u_servo_mix (
            .aclk         (aclk),
            .en           (en[NUM_STAGES-1:MIX_STAGE]),
            .roll         (roll),
            .pitch        (pitch),
            .coll_scaled  (coll_scaled),
            .factor_roll  ($signed(cfg_reg.roll_factors[16*k +: 16])),
            .factor_pitch ($signed(cfg_reg.pitch_factors[16*k +: 16])),
            .trim         (cfg_reg.servo_trims[11*k +: 11]),
            .servo        (servo[k])
        );
    end

    assign m_servo_one        = servo[0];
    assign m_servo_two        = servo[1];
    assign m_servo_three      = servo[2];
    assign m_cw_drive         = $signed(side.cw_drive);
    assign m_ccw_drive        = $signed(side.ccw_drive);
    assign m_limit_roll_pitch = side.limit_roll_pitch;
    assign m_limit_yaw        = side.limit_yaw;
    assign m_limit_coll_low   = side.limit_coll_low;
    assign m_limit_coll_high  = side.limit_coll_high;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import cxsm_pkg::*;

    localparam int          FRAC_BITS        = 14;
    localparam int          COLL_MIN_DEFAULT = 1250;
    localparam int          COLL_MAX_DEFAULT = 1750;
    localparam longint      ANGLE_FULL       = 4500;
    localparam longint      SERVO_DEN        = longint'(10) << FRAC_BITS;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int          BLOCKS           = 9;
    localparam int          BLOCK_ITEMS      = 61;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_SERVO_TRIMS + 4'd1;

    typedef enum logic [1:0] {
        MODE_STOP   = 2'd0,
        MODE_IDLE   = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_SPARE  = 2'd3
    } rotor_mode_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] throttle;
        logic signed [15:0] yaw;
        rotor_mode_t        mode;
    } mix_cmd_t;

    typedef struct packed {
        logic signed [15:0] servo_one;
        logic signed [15:0] servo_two;
        logic signed [15:0] servo_three;
        logic signed [15:0] cw_drive;
        logic signed [15:0] ccw_drive;
        logic               limit_roll_pitch;
        logic               limit_yaw;
        logic               limit_coll_low;
        logic               limit_coll_high;
    } mix_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [15:0]    s_roll_cmd = '0;
    logic signed [15:0]    s_pitch_cmd = '0;
    logic signed [15:0]    s_throttle_cmd = '0;
    logic signed [15:0]    s_yaw_cmd = '0;
    logic [1:0]            s_rotor_mode = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [15:0]    m_servo_one;
    logic signed [15:0]    m_servo_two;
    logic signed [15:0]    m_servo_three;
    logic signed [15:0]    m_cw_drive;
    logic signed [15:0]    m_ccw_drive;
    logic                  m_limit_roll_pitch;
    logic                  m_limit_yaw;
    logic                  m_limit_coll_low;
    logic                  m_limit_coll_high;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cfg_t        mix_cfg;
    mix_cmd_t    cmd_queue[$];
    mix_result_t expected_mix[$];
    int          send_idle_pct = 12;
    int          recv_idle_pct = 83;
    int unsigned cycle_count = 0;
    int unsigned cmds_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned settings_loaded = 0;

    coax_swashplate_mixer #(
        .FACTOR_FRAC_BITS (FRAC_BITS),
        .DEFAULT_COLL_MIN (COLL_MIN_DEFAULT),
        .DEFAULT_COLL_MAX (COLL_MAX_DEFAULT)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_roll_cmd         (s_roll_cmd),
        .s_pitch_cmd        (s_pitch_cmd),
        .s_throttle_cmd     (s_throttle_cmd),
        .s_yaw_cmd          (s_yaw_cmd),
        .s_rotor_mode       (s_rotor_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_servo_one        (m_servo_one),
        .m_servo_two        (m_servo_two),
        .m_servo_three      (m_servo_three),
        .m_cw_drive         (m_cw_drive),
        .m_ccw_drive        (m_ccw_drive),
        .m_limit_roll_pitch (m_limit_roll_pitch),
        .m_limit_yaw        (m_limit_yaw),
        .m_limit_coll_low   (m_limit_coll_low),
        .m_limit_coll_high  (m_limit_coll_high),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic longint scale_to_limit(input logic signed [15:0] cmd,
                                              input logic [12:0] lim, inout bit clamped);
        longint l;
        longint v;
        l = longint'(lim);
        v = (longint'(cmd) * l) / ANGLE_FULL;
        if (v < -l) begin
            v = -l;
            clamped = 1'b1;
        end
        if (v > l) begin
            v = l;
            clamped = 1'b1;
        end
        return v;
    endfunction

    function automatic mix_result_t predict_mix(input mix_cmd_t c, input cfg_t cfg);
        mix_result_t r;
        bit          rp_clamped;
        longint      roll, pitch, yaw, thr, coll, lo, hi, cs, rf, pf, trim, num;
        logic signed [15:0] servo [3];
        int          k;
        rp_clamped = 1'b0;
        roll  = scale_to_limit(c.roll, cfg.roll_limit, rp_clamped);
        pitch = scale_to_limit(c.pitch, cfg.pitch_limit, rp_clamped);
        r.limit_roll_pitch = rp_clamped;

        thr = longint'(c.throttle);
        r.limit_yaw = 1'b0;
        if (thr < YAW_MIN_THROTTLE) begin
            yaw = 0;
            r.limit_yaw = 1'b1;
        end else begin
            yaw = (longint'(c.yaw) * 2) / 9;
            if (yaw < -YAW_LIMIT) begin
                yaw = -YAW_LIMIT;
                r.limit_yaw = 1'b1;
            end
            if (yaw > YAW_LIMIT) begin
                yaw = YAW_LIMIT;
                r.limit_yaw = 1'b1;
            end
        end

        coll = longint'($signed(cfg.collective_target));
        r.limit_coll_low  = (coll <= 0);
        r.limit_coll_high = (coll >= COLL_FULL);
        if (coll <= 0) begin
            coll = 0;
        end
        if (coll >= COLL_FULL) begin
            coll = COLL_FULL;
        end

        lo = longint'(cfg.collective_low);
        hi = longint'(cfg.collective_high);
        if (lo >= hi) begin
            lo = COLL_MIN_DEFAULT;
            hi = COLL_MAX_DEFAULT;
        end
        cs = (coll * (hi - lo) + (lo - COLL_FULL) * COLL_FULL) / COLL_FULL;

        for (k = 0; k < 3; k++) begin
            rf   = longint'($signed(cfg.roll_factors[16*k +: 16]));
            pf   = longint'($signed(cfg.pitch_factors[16*k +: 16]));
            trim = longint'(cfg.servo_trims[11*k +: 11]);
            num  = rf * roll + pf * pitch + (cs + trim - TRIM_CENTER) * SERVO_DEN;
            servo[k] = clip16(num / SERVO_DEN);
        end
        r.servo_one   = servo[0];
        r.servo_two   = servo[1];
        r.servo_three = servo[2];

        if (c.mode == MODE_STOP || c.mode == MODE_IDLE) begin
            r.cw_drive  = '0;
            r.ccw_drive = '0;
        end else begin
            r.cw_drive  = clip16(thr - yaw);
            r.ccw_drive = clip16(thr + yaw);
        end
        return r;
    endfunction

    function automatic string fmt_mix(input mix_result_t r);
        return $sformatf("servo %0d/%0d/%0d cw %0d ccw %0d flags rp=%b yaw=%b lo=%b hi=%b",
                         r.servo_one, r.servo_two, r.servo_three, r.cw_drive, r.ccw_drive,
                         r.limit_roll_pitch, r.limit_yaw, r.limit_coll_low,
                         r.limit_coll_high);
    endfunction

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 16'(int'($urandom_range(9000)) - int'(ANGLE_FULL));
            5, 6, 7:       return 16'($urandom);
            8:             return 16'sh7FFF - 16'($urandom_range(3));
            default:       return 16'sh8000 + 16'($urandom_range(3));
        endcase
    endfunction

    function automatic mix_cmd_t random_cmd();
        mix_cmd_t c;
        c.roll  = random_angle();
        c.pitch = random_angle();
        case ($urandom_range(9))
            0, 1, 2: c.throttle = 16'($urandom_range(400));
            3, 4, 5: c.throttle = 16'($urandom_range(1000));
            6, 7:    c.throttle = 16'($urandom);
            8:       c.throttle = 16'($urandom_range(205, 195));
            default: c.throttle = 16'(-int'($urandom_range(1000)));
        endcase
        if ($urandom_range(1) == 0) begin
            c.yaw = 16'(int'($urandom_range(1200)) - 600);
        end else begin
            c.yaw = random_angle();
        end
        c.mode = rotor_mode_t'($urandom_range(3));
        return c;
    endfunction

    task automatic queue_cmd(input int roll, input int pitch, input int thr, input int yaw,
                             input rotor_mode_t mode);
        mix_cmd_t c;
        c.roll     = 16'(roll);
        c.pitch    = 16'(pitch);
        c.throttle = 16'(thr);
        c.yaw      = 16'(yaw);
        c.mode     = mode;
        cmd_queue.push_back(c);
    endtask

    // unused upper data bits get random junk now and then; the register must mask them
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v,
                             input int w);
        logic [47:0] data;
        data = v;
        if (w < CFG_DATA_W && $urandom_range(3) == 0) begin
            data = data | (48'({$urandom, $urandom}) & ~((48'd1 << w) - 48'd1));
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_ROLL_FACTORS:      mix_cfg.roll_factors      = data[47:0];
            REG_PITCH_FACTORS:     mix_cfg.pitch_factors     = data[47:0];
            REG_ROLL_LIMIT:        mix_cfg.roll_limit        = data[12:0];
            REG_PITCH_LIMIT:       mix_cfg.pitch_limit       = data[12:0];
            REG_COLLECTIVE_LOW:    mix_cfg.collective_low    = data[10:0];
            REG_COLLECTIVE_HIGH:   mix_cfg.collective_high   = data[10:0];
            REG_COLLECTIVE_TARGET: mix_cfg.collective_target = data[11:0];
            REG_SERVO_TRIMS:       mix_cfg.servo_trims       = data[32:0];
            default: ;
        endcase
    endtask

    task automatic program_setting(input cfg_t s);
        write_reg(REG_ROLL_FACTORS, 48'(s.roll_factors), $bits(s.roll_factors));
        write_reg(REG_PITCH_FACTORS, 48'(s.pitch_factors), $bits(s.pitch_factors));
        write_reg(REG_ROLL_LIMIT, 48'(s.roll_limit), $bits(s.roll_limit));
        write_reg(REG_PITCH_LIMIT, 48'(s.pitch_limit), $bits(s.pitch_limit));
        write_reg(REG_COLLECTIVE_LOW, 48'(s.collective_low), $bits(s.collective_low));
        write_reg(REG_COLLECTIVE_HIGH, 48'(s.collective_high), $bits(s.collective_high));
        write_reg(REG_COLLECTIVE_TARGET, 48'(s.collective_target),
                  $bits(s.collective_target));
        write_reg(REG_SERVO_TRIMS, 48'(s.servo_trims), $bits(s.servo_trims));
        // out-of-map index, must be ignored
        write_reg(FIRST_UNUSED_REG + CFG_IDX_W'($urandom_range(7)),
                  48'({$urandom, $urandom}), CFG_DATA_W);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [12:0] random_limit();
        case ($urandom_range(4))
            0:       return 13'd0;
            1:       return 13'(ANGLE_FULL);
            2:       return 13'($urandom_range(8191));
            default: return 13'($urandom_range(4500));
        endcase
    endfunction

    task automatic program_random_setting();
        cfg_t s;
        int   k;
        if ($urandom_range(1) == 0) begin
            s.roll_factors  = {$urandom, $urandom};
            s.pitch_factors = {$urandom, $urandom};
        end else begin
            for (k = 0; k < 3; k++) begin
                s.roll_factors[16*k +: 16]  = 16'(int'($urandom_range(32768)) - 16384);
                s.pitch_factors[16*k +: 16] = 16'(int'($urandom_range(32768)) - 16384);
            end
        end
        s.roll_limit  = random_limit();
        s.pitch_limit = random_limit();
        case ($urandom_range(3))
            0: begin
                s.collective_low  = 11'($urandom_range(2000, 1000));
                s.collective_high = 11'($urandom_range(2000, s.collective_low));
            end
            1: begin
                s.collective_high = 11'($urandom_range(1500, 1000));
                s.collective_low  = 11'($urandom_range(2000, s.collective_high));
            end
            2: begin
                s.collective_low  = 11'($urandom);
                s.collective_high = 11'($urandom);
            end
            default: begin
                s.collective_low  = 11'($urandom_range(1499, 1000));
                s.collective_high = 11'($urandom_range(2000, 1500));
            end
        endcase
        case ($urandom_range(3))
            0:       s.collective_target = 12'($urandom);
            1:       s.collective_target = 12'd0;
            2:       s.collective_target = 12'(COLL_FULL);
            default: s.collective_target = 12'(int'($urandom_range(3000)) - 1000);
        endcase
        if ($urandom_range(1) == 0) begin
            s.servo_trims = 33'({$urandom, $urandom});
        end else begin
            for (k = 0; k < 3; k++) begin
                s.servo_trims[11*k +: 11] = 11'($urandom_range(2000, 1000));
            end
        end
        program_setting(s);
    endtask

    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (cmd_queue.size() != 0 || s_valid || expected_mix.size() != 0);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_mix.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        mix_cmd_t sent;
        mix_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent.roll     = s_roll_cmd;
                sent.pitch    = s_pitch_cmd;
                sent.throttle = s_throttle_cmd;
                sent.yaw      = s_yaw_cmd;
                sent.mode     = rotor_mode_t'(s_rotor_mode);
                expected_mix.push_back(predict_mix(sent, mix_cfg));
                cmds_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_queue.pop_front();
                    s_valid        <= 1'b1;
                    s_roll_cmd     <= nxt.roll;
                    s_pitch_cmd    <= nxt.pitch;
                    s_throttle_cmd <= nxt.throttle;
                    s_yaw_cmd      <= nxt.yaw;
                    s_rotor_mode   <= nxt.mode;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        mix_result_t got;
        mix_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.servo_one        = m_servo_one;
            got.servo_two        = m_servo_two;
            got.servo_three      = m_servo_three;
            got.cw_drive         = m_cw_drive;
            got.ccw_drive        = m_ccw_drive;
            got.limit_roll_pitch = m_limit_roll_pitch;
            got.limit_yaw        = m_limit_yaw;
            got.limit_coll_low   = m_limit_coll_low;
            got.limit_coll_high  = m_limit_coll_high;
            results_checked++;
            if (expected_mix.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result transaction: %s", fmt_mix(got));
                end
            end else begin
                want = expected_mix.pop_front();
                if (got.servo_one !== want.servo_one || got.servo_two !== want.servo_two ||
                    got.servo_three !== want.servo_three ||
                    got.cw_drive !== want.cw_drive || got.ccw_drive !== want.ccw_drive ||
                    got.limit_roll_pitch !== want.limit_roll_pitch ||
                    got.limit_yaw !== want.limit_yaw ||
                    got.limit_coll_low !== want.limit_coll_low ||
                    got.limit_coll_high !== want.limit_coll_high) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d mismatch", results_checked);
                        $display("  expected %s", fmt_mix(want));
                        $display("  actual   %s", fmt_mix(got));
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        cfg_t s;
        int   blk;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mix_cfg.roll_factors      = '0;
        mix_cfg.pitch_factors     = '0;
        mix_cfg.roll_limit        = LIMIT_RESET;
        mix_cfg.pitch_limit       = LIMIT_RESET;
        mix_cfg.collective_low    = COLL_LOW_RESET;
        mix_cfg.collective_high   = COLL_HIGH_RESET;
        mix_cfg.collective_target = COLL_TARGET_RESET;
        mix_cfg.servo_trims       = {3{TRIM_RESET}};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: command extremes, yaw threshold and clamps, all rotor modes
        queue_cmd(0, 0, 0, 0, MODE_STOP);
        queue_cmd(32767, -32768, 1000, 4500, MODE_ACTIVE);
        queue_cmd(-32768, 32767, 199, 100, MODE_ACTIVE);
        queue_cmd(4500, -4500, 200, -4500, MODE_ACTIVE);
        queue_cmd(100, 200, 500, 449, MODE_IDLE);
        queue_cmd(-1, 1, -32768, -32768, MODE_STOP);
        queue_cmd(0, 0, 32767, 32767, MODE_ACTIVE);
        queue_cmd(0, 0, 32767, -32768, MODE_SPARE);
        queue_cmd(4501, -4501, 32767, 450, MODE_ACTIVE);
        queue_cmd(-4500, 4500, 300, -454, MODE_ACTIVE);
        wait_for_drain();

        // inverted collective range falls back to defaults; negative setpoint
        s = mix_cfg;
        s.roll_factors      = {16'hC000, 16'hC000, 16'h4000};
        s.pitch_factors     = {16'h2000, 16'hE000, 16'h0000};
        s.roll_limit        = 13'd8191;
        s.pitch_limit       = 13'd0;
        s.collective_low    = 11'd1800;
        s.collective_high   = 11'd1200;
        s.collective_target = 12'(-1000);
        s.servo_trims       = {11'd1000, 11'd0, 11'd2047};
        program_setting(s);
        queue_cmd(4500, 4500, 600, 0, MODE_ACTIVE);
        queue_cmd(-4500, -4500, 600, 0, MODE_ACTIVE);
        queue_cmd(32767, 32767, 250, -4500, MODE_ACTIVE);
        queue_cmd(-32768, -32768, 250, 4500, MODE_IDLE);
        queue_cmd(1234, -2345, 800, 300, MODE_ACTIVE);
        queue_cmd(-17, 17, 199, -1, MODE_SPARE);
        queue_cmd(2250, -2250, 1000, -1000, MODE_ACTIVE);
        wait_for_drain();

        // extreme factors and trims, setpoint above full scale
        s.roll_factors      = {16'h7FFF, 16'h8000, 16'h7FFF};
        s.pitch_factors     = {16'h8000, 16'h7FFF, 16'h8000};
        s.roll_limit        = 13'(ANGLE_FULL);
        s.pitch_limit       = 13'(ANGLE_FULL);
        s.collective_low    = 11'd1000;
        s.collective_high   = 11'd2000;
        s.collective_target = 12'd2047;
        s.servo_trims       = {3{11'h7FF}};
        program_setting(s);
        queue_cmd(32767, 32767, 32767, 32767, MODE_ACTIVE);
        queue_cmd(-32768, -32768, -32768, -32768, MODE_ACTIVE);
        queue_cmd(32767, -32768, 1000, -32768, MODE_ACTIVE);
        queue_cmd(4500, 4500, 0, 0, MODE_STOP);
        queue_cmd(-4500, 4500, 200, 455, MODE_ACTIVE);
        queue_cmd(0, 0, 1, -455, MODE_IDLE);
        wait_for_drain();

        for (blk = 0; blk < BLOCKS; blk++) begin
            case (blk / 3)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            program_random_setting();
            repeat (BLOCK_ITEMS) cmd_queue.push_back(random_cmd());
            wait_for_drain();
        end

        repeat (2 * NUM_STAGES) @(posedge aclk);
        $display("%0d commands mixed under %0d register settings; %0d results checked",
                 cmds_accepted, settings_loaded, results_checked);
        $display("%0d mismatches, %0d results never delivered", mismatch_count,
                 expected_mix.size());
        if (mismatch_count == 0 && expected_mix.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
